/* design/stablit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled tinted alpha blit - shared definitions
// Image sizes, address widths, request/result types, operation, status and
// register codes, and the exact truncating divide-by-255 used by the blender.
// ----------------------------------------------------------------------------
package stablit_pkg;

  // Image geometry.
  localparam int SRC_W = 64;
  localparam int SRC_H = 64;
  localparam int DST_W = 64;
  localparam int DST_H = 64;

  localparam int SRC_PIXELS = SRC_W * SRC_H;
  localparam int DST_PIXELS = DST_W * DST_H;
  localparam int SRC_AW = (SRC_PIXELS > 1) ? $clog2(SRC_PIXELS) : 1;
  localparam int DST_AW = (DST_PIXELS > 1) ? $clog2(DST_PIXELS) : 1;

  // Width of linear addresses before range checking (holds 256 * 256).
  localparam int LIN_W = 17;

  // Scaling divider: (rect_size * offset) / rect_size.
  localparam int NUM_W  = 17;
  localparam int DEN_W  = 9;
  localparam int DIV_CW = $clog2(NUM_W + 1);

  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Operation codes.
  localparam logic [1:0] FUNC_WR_SRC = 2'd0;
  localparam logic [1:0] FUNC_WR_DST = 2'd1;
  localparam logic [1:0] FUNC_RD_DST = 2'd2;
  localparam logic [1:0] FUNC_BLIT   = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_DCLIP    = 3'd1;
  localparam logic [2:0] ST_SCLIP    = 3'd2;
  localparam logic [2:0] ST_TRANSP   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_OUTSIDE  = 3'd5;

  // Configuration register indexes.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 9;
  localparam logic [CFG_AW-1:0] REG_SRC_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SRC_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SRC_W = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SRC_H = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DST_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DST_Y = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DST_W = 3'd6;
  localparam logic [CFG_AW-1:0] REG_DST_H = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] pixel_addr;
    logic [31:0] pixel_value;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] tint;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic tint_en;
    logic mul_en;
  } blend_ctrl_t;

  // Truncating x / 255 for x below 65280. The estimate (x + x/256 + 1) / 256
  // is within one of the true quotient; the remainder sign fixes it.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0]        s;
    logic [8:0]         q1;
    logic signed [18:0] r;
    logic [8:0]         q;
    s  = 17'(x) + 17'(x[15:8]) + 17'd1;
    q1 = s[16:8];
    r  = $signed({3'b000, x}) - $signed({2'b00, q1, 8'h00}) + $signed({10'd0, q1});
    if (r < 0) begin
      q = q1 - 9'd1;
    end else if (r >= 19'sd255) begin
      q = q1 + 9'd1;
    end else begin
      q = q1;
    end
    return q[7:0];
  endfunction

endpackage

/* design/stablit_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module stablit_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/stablit_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaling divider
// Restoring divider, one quotient bit per cycle. fin pulses for one cycle
// once the quotient is complete; the quotient then holds until restarted.
// ----------------------------------------------------------------------------
module stablit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stablit_pkg::NUM_W-1:0] num,
  input  logic [stablit_pkg::DEN_W-1:0] den,
  output logic [stablit_pkg::NUM_W-1:0] quo,
  output logic                          fin
);
  import stablit_pkg::*;

  logic              run;
  logic [DIV_CW-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CW'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (run) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

/* design/stablit_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tint and source-over blend
// Stage one tints the source pixel, stage two forms the weighted channel
// products; the blended pixel is formed from the stage two registers.
// ----------------------------------------------------------------------------
module stablit_blend (
  input  logic                      clk,
  input  stablit_pkg::blend_ctrl_t  ctrl,
  input  logic [31:0]               src_pix,
  input  logic [31:0]               dst_pix,
  input  logic [31:0]               tint,
  output logic [7:0]                alpha,
  output logic [31:0]               pixel
);
  import stablit_pkg::*;

  logic [7:0]  sc [4];
  logic [7:0]  dq [4];
  logic [15:0] ps [3];
  logic [15:0] pd [3];
  logic [15:0] pa;
  logic [15:0] csum [3];

  always_ff @(posedge clk) begin
    if (ctrl.tint_en) begin
      for (int k = 0; k < 4; k++) begin
        sc[k] <= div255(16'(src_pix[8*k +: 8]) * 16'(tint[8*k +: 8]));
        dq[k] <= dst_pix[8*k +: 8];
      end
    end
    if (ctrl.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        ps[k] <= 16'(sc[k]) * 16'(sc[3]);
        pd[k] <= 16'(dq[k]) * 16'(CHAN_MAX - sc[3]);
      end
      pa <= 16'(dq[3]) * 16'(CHAN_MAX - sc[3]);
    end
  end

  assign alpha = sc[3];

  // Weights sum to 255, so each channel sum stays within 16 bits.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum[k] = ps[k] + pd[k];
      pixel[8*k +: 8] = div255(csum[k]);
    end
    pixel[31:24] = sc[3] + div255(pa);
  end

endmodule

/* design/scaled_tinted_alpha_blit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled tinted alpha blit core
// Source and destination RGBA8 images in on-chip RAM; pixel write, pixel
// read and nearest-neighbour scaled, tinted, source-over blit per position.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and each request
// gives exactly one result, shown on rsp for the single cycle in which done
// is high; the receiver cannot stall it, so it must take every result. Pixel
// writes answer in the cycle after they are taken, and the next request may
// follow at once. A pixel read goes through the destination RAM read port
// and a wait state, or answers directly if the address lies beyond the
// image. A blit position that is rejected on its rectangle sizes or offsets
// answers in the next cycle; otherwise the two 17-step scaling dividers run
// side by side, the address state checks clipping, the multiply state checks
// for transparency and the blend state writes back. Configuration writes
// are always ready and may only be issued while the core is idle.
module scaled_tinted_alpha_blit_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  stablit_pkg::req_t              req,
  output logic                           done,
  output stablit_pkg::rsp_t              rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stablit_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [stablit_pkg::CFG_DW-1:0] cfg_data
);
  import stablit_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_TINT   = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_BLEND  = 3'd6;

  logic [2:0] state, state_next;
  logic       done_next;
  rsp_t       rsp_next;
  req_t       cmd;

  // Rectangle registers.
  logic [7:0] src_x, src_y;
  logic [8:0] src_w, src_h, dst_x, dst_y, dst_w, dst_h;

  logic             accept;
  logic [LIN_W-1:0] addr_ext;
  logic             src_in_range, dst_in_range;
  logic             rect_empty, pos_outside;

  // Memory ports.
  logic              src_we, src_re, dst_we, dst_re;
  logic [SRC_AW-1:0] src_wa, src_ra;
  logic [DST_AW-1:0] dst_wa, dst_ra;
  logic [31:0]       dst_wd, src_rd, dst_rd;

  // Dividers.
  logic             div_start;
  logic [NUM_W-1:0] num_y, num_x, quo_y, quo_x;
  logic             fin_y, fin_x;

  // Coordinate checks.
  logic [9:0]       dy, dx;
  logic [17:0]      sy, sx;
  logic             dy_clip, dx_clip, sy_clip, sx_clip;
  logic [2:0]       clip_calc, clip_st;
  logic [LIN_W-1:0] src_lin, dst_lin;
  logic [SRC_AW-1:0] src_pa;
  logic [DST_AW-1:0] dst_pa;

  blend_ctrl_t bctl;
  logic [7:0]  blend_alpha;
  logic [31:0] blend_pix;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign addr_ext     = LIN_W'(req.pixel_addr);
  assign src_in_range = (addr_ext < LIN_W'(SRC_PIXELS));
  assign dst_in_range = (addr_ext < LIN_W'(DST_PIXELS));
  assign rect_empty   = (src_w == '0) || (src_h == '0) || (dst_w == '0) || (dst_h == '0);
  assign pos_outside  = ({1'b0, req.col} >= dst_w) || ({1'b0, req.row} >= dst_h);

  assign num_y = NUM_W'(src_h) * NUM_W'(req.row);
  assign num_x = NUM_W'(src_w) * NUM_W'(req.col);

  // Destination coordinates wrap as 10-bit two's complement.
  assign dy      = {dst_y[8], dst_y} + {2'b00, cmd.row};
  assign dx      = {dst_x[8], dst_x} + {2'b00, cmd.col};
  assign dy_clip = dy[9] || (dy[8:0] >= 9'(DST_H));
  assign dx_clip = dx[9] || (dx[8:0] >= 9'(DST_W));
  assign sy      = 18'(src_y) + 18'(quo_y);
  assign sx      = 18'(src_x) + 18'(quo_x);
  assign sy_clip = (sy >= 18'(SRC_H));
  assign sx_clip = (sx >= 18'(SRC_W));

  always_comb begin
    if (dy_clip) begin
      clip_calc = ST_DCLIP;
    end else if (sy_clip) begin
      clip_calc = ST_SCLIP;
    end else if (dx_clip) begin
      clip_calc = ST_DCLIP;
    end else if (sx_clip) begin
      clip_calc = ST_SCLIP;
    end else begin
      clip_calc = ST_DONE;
    end
  end

  assign src_lin = LIN_W'(LIN_W'(sy[7:0]) * LIN_W'(SRC_W)) + LIN_W'(sx[7:0]);
  assign dst_lin = LIN_W'(LIN_W'(dy[7:0]) * LIN_W'(DST_W)) + LIN_W'(dx[7:0]);

  assign src_wa = addr_ext[SRC_AW-1:0];
  assign src_ra = src_pa;
  assign dst_wa = (state == S_BLEND) ? dst_pa : addr_ext[DST_AW-1:0];
  assign dst_wd = (state == S_BLEND) ? blend_pix : req.pixel_value;
  assign dst_ra = (state == S_ADDR) ? dst_pa : addr_ext[DST_AW-1:0];

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    rsp_next   = '0;
    src_we     = 1'b0;
    src_re     = 1'b0;
    dst_we     = 1'b0;
    dst_re     = 1'b0;
    div_start  = 1'b0;
    bctl       = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FUNC_WR_SRC: begin
              src_we    = src_in_range;
              done_next = 1'b1;
            end
            FUNC_WR_DST: begin
              dst_we    = dst_in_range;
              done_next = 1'b1;
            end
            FUNC_RD_DST: begin
              if (dst_in_range) begin
                dst_re     = 1'b1;
                state_next = S_RDWAIT;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              if (rect_empty) begin
                done_next       = 1'b1;
                rsp_next.status = ST_EMPTY;
              end else if (pos_outside) begin
                done_next       = 1'b1;
                rsp_next.status = ST_OUTSIDE;
              end else begin
                div_start  = 1'b1;
                state_next = S_DIV;
              end
            end
          endcase
        end
      end
      S_RDWAIT: begin
        done_next           = 1'b1;
        rsp_next.read_value = dst_rd;
        state_next          = S_IDLE;
      end
      S_DIV: begin
        if (fin_y) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        if (clip_st != ST_DONE) begin
          done_next       = 1'b1;
          rsp_next.status = clip_st;
          state_next      = S_IDLE;
        end else begin
          src_re     = 1'b1;
          dst_re     = 1'b1;
          state_next = S_TINT;
        end
      end
      S_TINT: begin
        bctl.tint_en = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        if (blend_alpha == 8'd0) begin
          done_next       = 1'b1;
          rsp_next.status = ST_TRANSP;
          state_next      = S_IDLE;
        end else begin
          bctl.mul_en = 1'b1;
          state_next  = S_BLEND;
        end
      end
      S_BLEND: begin
        dst_we              = 1'b1;
        done_next           = 1'b1;
        rsp_next.read_value = blend_pix;
        state_next          = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      src_x <= '0;
      src_y <= '0;
      src_w <= '0;
      src_h <= '0;
      dst_x <= '0;
      dst_y <= '0;
      dst_w <= '0;
      dst_h <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_SRC_X: src_x <= cfg_data[7:0];
          REG_SRC_Y: src_y <= cfg_data[7:0];
          REG_SRC_W: src_w <= cfg_data;
          REG_SRC_H: src_h <= cfg_data;
          REG_DST_X: dst_x <= cfg_data;
          REG_DST_Y: dst_y <= cfg_data;
          REG_DST_W: dst_w <= cfg_data;
          REG_DST_H: dst_h <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (accept) begin
      cmd <= req;
    end
    if ((state == S_DIV) && fin_y) begin
      clip_st <= clip_calc;
      src_pa  <= src_lin[SRC_AW-1:0];
      dst_pa  <= dst_lin[DST_AW-1:0];
    end
  end

  stablit_ram #(
    .DEPTH (SRC_PIXELS),
    .WIDTH (32),
    .AW    (SRC_AW)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_wa),
    .wdata (req.pixel_value),
    .re    (src_re),
    .raddr (src_ra),
    .rdata (src_rd)
  );

  stablit_ram #(
    .DEPTH (DST_PIXELS),
    .WIDTH (32),
    .AW    (DST_AW)
  ) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_wa),
    .wdata (dst_wd),
    .re    (dst_re),
    .raddr (dst_ra),
    .rdata (dst_rd)
  );

  stablit_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .den   (dst_h),
    .quo   (quo_y),
    .fin   (fin_y)
  );

  stablit_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (dst_w),
    .quo   (quo_x),
    .fin   (fin_x)
  );

  stablit_blend u_blend (
    .clk     (clk),
    .ctrl    (bctl),
    .src_pix (src_rd),
    .dst_pix (dst_rd),
    .tint    (cmd.tint),
    .alpha   (blend_alpha),
    .pixel   (blend_pix)
  );

`ifndef SYNTHESIS
  // Both scaling dividers start together and must finish together.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    fin_y == fin_x)
    else $error("row and column dividers out of step");

  // An accepted request either answers next cycle or keeps the core busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted request neither answered nor in progress");

  // A blend write-back happens only for a visible tinted pixel.
  a_blend_alpha: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLEND) |-> (blend_alpha != 8'd0))
    else $error("blend reached with zero alpha");

  // The write-back cycle always produces a completed result.
  a_blend_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLEND) |=> (done && (rsp.status == ST_DONE)))
    else $error("blend without completed result");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the scaled tinted alpha blit core
// Fills the source and destination images through pixel write requests, then
// runs blit positions under a series of rectangle settings. A local model of
// the images and the scale/clip/tint/blend math predicts every result, and a
// monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import stablit_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_PRINTS   = 40;
  localparam int CHAN_FULL    = int'(CHAN_MAX);

  typedef struct {
    req_t item;
    int   gap;
  } pixel_op_t;

  typedef struct {
    logic [2:0] status;
    int         src_idx;
    int         dst_idx;
  } blit_target_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  req_t                req = '0;
  logic                cfg_valid = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;
  logic                busy;
  logic                done;
  rsp_t                rsp;
  logic                cfg_ready;

  // Model state, updated in acceptance order.
  logic [31:0] src_img [SRC_PIXELS];
  logic [31:0] dst_img [DST_PIXELS];
  logic [8:0]  rect_reg [8];

  // Which pixels the stimulus has written so far, so that nothing unwritten
  // is ever read.
  bit src_loaded [SRC_PIXELS];
  bit dst_loaded [DST_PIXELS];
  int dst_loaded_list [$];

  pixel_op_t pixel_op_q [$];
  rsp_t      expected_rsp [$];

  int gap_mode = 0;
  int gap_cnt = 0;
  int queued_total = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int err_count = 0;
  int cfg_writes = 0;
  int phase_no = 0;
  int idle_cycles = 0;
  int blit_status_cnt [8];

  scaled_tinted_alpha_blit_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
               results_seen);
    end
  endtask

  // Maps a rectangle position to the source and destination pixels it
  // touches, applying the empty, outside and clipping checks in order.
  function automatic blit_target_t locate_blit(input logic [7:0] col,
                                               input logic [7:0] row);
    blit_target_t t;
    int sw, sh, dw, dh, dx, dy, sx, sy;
    sw = int'(rect_reg[REG_SRC_W]);
    sh = int'(rect_reg[REG_SRC_H]);
    dw = int'(rect_reg[REG_DST_W]);
    dh = int'(rect_reg[REG_DST_H]);
    t.status  = ST_DONE;
    t.src_idx = 0;
    t.dst_idx = 0;
    if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
      t.status = ST_EMPTY;
    end else if (int'(col) >= dw || int'(row) >= dh) begin
      t.status = ST_OUTSIDE;
    end else begin
      dy = $signed(rect_reg[REG_DST_Y]);
      dy = dy + int'(row);
      dx = $signed(rect_reg[REG_DST_X]);
      dx = dx + int'(col);
      sy = int'(rect_reg[REG_SRC_Y][7:0]) + (sh * int'(row)) / dh;
      sx = int'(rect_reg[REG_SRC_X][7:0]) + (sw * int'(col)) / dw;
      if (dy < 0 || dy >= DST_H) begin
        t.status = ST_DCLIP;
      end else if (sy >= SRC_H) begin
        t.status = ST_SCLIP;
      end else if (dx < 0 || dx >= DST_W) begin
        t.status = ST_DCLIP;
      end else if (sx >= SRC_W) begin
        t.status = ST_SCLIP;
      end else begin
        t.src_idx = sy * SRC_W + sx;
        t.dst_idx = dy * DST_W + dx;
      end
    end
    return t;
  endfunction

  function automatic rsp_t predict_pixel_result(input req_t r);
    rsp_t         res;
    blit_target_t t;
    logic [31:0]  sp, dp, np;
    int           a, sc, c;
    res = '0;
    case (r.func)
      FUNC_WR_SRC: begin
        if (int'(r.pixel_addr) < SRC_PIXELS) src_img[r.pixel_addr] = r.pixel_value;
      end
      FUNC_WR_DST: begin
        if (int'(r.pixel_addr) < DST_PIXELS) dst_img[r.pixel_addr] = r.pixel_value;
      end
      FUNC_RD_DST: begin
        if (int'(r.pixel_addr) < DST_PIXELS) res.read_value = dst_img[r.pixel_addr];
      end
      default: begin
        t = locate_blit(r.col, r.row);
        res.status = t.status;
        if (t.status == ST_DONE) begin
          sp = src_img[t.src_idx];
          a = int'(sp[31:24]) * int'(r.tint[31:24]) / CHAN_FULL;
          if (a == 0) begin
            res.status = ST_TRANSP;
          end else begin
            dp = dst_img[t.dst_idx];
            for (int k = 0; k < 3; k++) begin
              sc = int'(sp[8*k +: 8]) * int'(r.tint[8*k +: 8]) / CHAN_FULL;
              c = (sc * a + int'(dp[8*k +: 8]) * (CHAN_FULL - a)) / CHAN_FULL;
              np[8*k +: 8] = c[7:0];
            end
            c = a + int'(dp[31:24]) * (CHAN_FULL - a) / CHAN_FULL;
            np[31:24] = c[7:0];
            dst_img[t.dst_idx] = np;
            res.read_value = np;
          end
        end
      end
    endcase
    return res;
  endfunction

  // ---- stimulus helpers ----

  function automatic int pick_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  // Alpha is pushed to its extremes often, since it decides blending.
  function automatic logic [31:0] rand_pixel();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[31:24] = 8'h00;
      1: v[31:24] = 8'hFF;
      2: v = 32'hFFFF_FFFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic req_t rand_req(input logic [1:0] func);
    req_t r;
    r.func        = func;
    r.pixel_addr  = 12'($urandom);
    r.pixel_value = $urandom;
    r.col         = 8'($urandom);
    r.row         = 8'($urandom);
    r.tint        = $urandom;
    return r;
  endfunction

  function automatic void queue_op(input req_t r);
    pixel_op_t op;
    op.item = r;
    op.gap  = pick_gap();
    if (r.func == FUNC_WR_SRC) begin
      src_loaded[r.pixel_addr] = 1'b1;
    end else if (r.func == FUNC_WR_DST && !dst_loaded[r.pixel_addr]) begin
      dst_loaded[r.pixel_addr] = 1'b1;
      dst_loaded_list.push_back(int'(r.pixel_addr));
    end
    pixel_op_q.push_back(op);
    queued_total++;
  endfunction

  function automatic void queue_write(input logic [1:0] func, input int addr,
                                      input logic [31:0] value);
    req_t r;
    r = rand_req(func);
    r.pixel_addr  = addr[11:0];
    r.pixel_value = value;
    queue_op(r);
  endfunction

  function automatic void queue_read(input int addr);
    req_t r;
    r = rand_req(FUNC_RD_DST);
    r.pixel_addr = addr[11:0];
    queue_op(r);
  endfunction

  // Queues a blit position, first loading whatever pixels it will read.
  function automatic blit_target_t queue_blit(input logic [7:0] col, input logic [7:0] row,
                                              input logic [31:0] tint, input bit force_src,
                                              input logic [31:0] src_pix);
    blit_target_t t;
    req_t         r;
    t = locate_blit(col, row);
    if (t.status == ST_DONE) begin
      if (force_src || !src_loaded[t.src_idx]) queue_write(FUNC_WR_SRC, t.src_idx, src_pix);
      if (!dst_loaded[t.dst_idx]) queue_write(FUNC_WR_DST, t.dst_idx, rand_pixel());
    end
    r = rand_req(FUNC_BLIT);
    r.col  = col;
    r.row  = row;
    r.tint = tint;
    queue_op(r);
    return t;
  endfunction

  function automatic int pick_read_addr();
    int a;
    a = $urandom_range(0, DST_PIXELS - 1);
    if (!dst_loaded[a]) a = dst_loaded_list[$urandom_range(0, dst_loaded_list.size() - 1)];
    return a;
  endfunction

  function automatic logic [8:0] rand_size();
    case ($urandom_range(0, 19))
      0: return 9'd0;
      1, 2: return 9'd256;
      3, 4: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [8:0] rand_src_origin();
    return ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 255))
                                       : 9'($urandom_range(0, 63));
  endfunction

  function automatic logic [8:0] rand_dst_origin();
    int v;
    if ($urandom_range(0, 9) < 7) v = int'($urandom_range(0, 79)) - 16;
    else v = int'($urandom_range(0, 511)) - 256;
    return v[8:0];
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    rect_reg[idx] = (idx == REG_SRC_X || idx == REG_SRC_Y) ? {1'b0, val[7:0]} : val;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic program_rect(input logic [8:0] sx, input logic [8:0] sy,
                              input logic [8:0] sw, input logic [8:0] sh,
                              input logic [8:0] dx, input logic [8:0] dy,
                              input logic [8:0] dw, input logic [8:0] dh);
    write_reg(REG_SRC_X, sx);
    write_reg(REG_SRC_Y, sy);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_X, dx);
    write_reg(REG_DST_Y, dy);
    write_reg(REG_DST_W, dw);
    write_reg(REG_DST_H, dh);
  endtask

  task automatic wait_drained();
    while (results_seen < queued_total || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_random_phase(input int n_ops);
    blit_target_t t;
    int           pick, lim_c, lim_r;
    logic [7:0]   col, row;
    gap_mode = phase_no % 3;
    phase_no++;
    lim_c = (rect_reg[REG_DST_W] > 9'd256) ? 256 : int'(rect_reg[REG_DST_W]);
    lim_r = (rect_reg[REG_DST_H] > 9'd256) ? 256 : int'(rect_reg[REG_DST_H]);
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // Mostly positions inside the rectangle, a few anywhere.
        col = (lim_c > 0 && $urandom_range(0, 6) != 0) ? 8'($urandom_range(0, lim_c - 1))
                                                        : 8'($urandom);
        row = (lim_r > 0 && $urandom_range(0, 6) != 0) ? 8'($urandom_range(0, lim_r - 1))
                                                        : 8'($urandom);
        t = queue_blit(col, row, rand_pixel(), $urandom_range(0, 3) == 0, rand_pixel());
        if (t.status == ST_DONE && $urandom_range(0, 2) == 0) queue_read(t.dst_idx);
      end else if (pick < 70) begin
        queue_write(FUNC_WR_SRC, $urandom_range(0, SRC_PIXELS - 1), rand_pixel());
      end else if (pick < 85) begin
        queue_write(FUNC_WR_DST, $urandom_range(0, DST_PIXELS - 1), rand_pixel());
      end else begin
        queue_read(pick_read_addr());
      end
    end
    wait_drained();
  endtask

  // ---- driver: offers queued requests after each one's idle gap ----
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      start <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (start && !busy) begin
        want = predict_pixel_result(req);
        expected_rsp.push_back(want);
        accepted_cnt++;
        if (req.func == FUNC_BLIT) blit_status_cnt[want.status]++;
      end
      if (!start || !busy) begin
        if (pixel_op_q.size() != 0 && gap_cnt >= pixel_op_q[0].gap) begin
          req   <= pixel_op_q[0].item;
          start <= 1'b1;
          void'(pixel_op_q.pop_front());
          gap_cnt = 0;
        end else begin
          start <= 1'b0;
          if (pixel_op_q.size() != 0) gap_cnt++;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with no request pending", rsp.read_value, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.read_value !== want.read_value) begin
          report_mismatch("read_value", rsp.read_value, want.read_value);
        end
        if (rsp.status !== want.status) begin
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        end
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Stalled for %0d cycles with %0d results outstanding", idle_cycles,
               expected_rsp.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    blit_target_t t;
    for (int i = 0; i < 8; i++) begin
      rect_reg[i] = '0;
      blit_status_cnt[i] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings leave every rectangle empty.
    gap_mode = 0;
    void'(queue_blit(8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0, '0));
    queue_write(FUNC_WR_SRC, 0, 32'hFFFF_FFFF);
    queue_write(FUNC_WR_SRC, SRC_PIXELS - 1, 32'h0000_0000);
    queue_write(FUNC_WR_DST, 0, 32'h0000_0000);
    queue_write(FUNC_WR_DST, DST_PIXELS - 1, 32'hFFFF_FFFF);
    queue_read(0);
    queue_read(DST_PIXELS - 1);
    wait_drained();

    // Rectangles placed so that each clip check fires in turn: destination
    // row, source row, destination column, source column.
    gap_mode = 1;
    program_rect(9'd2, 9'd60, 9'd64, 9'd64, 9'h1FF, 9'h1FF, 9'd64, 9'd64);
    void'(queue_blit(8'd255, 8'd0, 32'hFFFF_FFFF, 1'b0, '0));
    void'(queue_blit(8'd0, 8'd255, 32'hFFFF_FFFF, 1'b0, '0));
    void'(queue_blit(8'd5, 8'd0, 32'hFFFF_FFFF, 1'b0, '0));
    void'(queue_blit(8'd5, 8'd5, 32'hFFFF_FFFF, 1'b0, '0));
    void'(queue_blit(8'd0, 8'd1, 32'hFFFF_FFFF, 1'b0, '0));
    void'(queue_blit(8'd62, 8'd1, 32'hFFFF_FFFF, 1'b0, '0));
    t = queue_blit(8'd3, 8'd1, 32'hFFFF_FFFF, 1'b1, 32'hFF12_3456);
    void'(queue_blit(8'd3, 8'd1, 32'h00FF_FFFF, 1'b1, 32'hFFFF_FFFF));
    void'(queue_blit(8'd4, 8'd1, 32'h8080_8080, 1'b1, 32'h80C0_FF10));
    void'(queue_blit(8'd4, 8'd1, 32'hFFFF_FFFF, 1'b1, 32'h01FF_FFFF));
    // Alpha product below 255 truncates to a transparent pixel.
    void'(queue_blit(8'd4, 8'd2, 32'h01FF_FFFF, 1'b1, 32'hFEFF_FFFF));
    queue_read(t.dst_idx);
    wait_drained();

    // Fixed settings covering the register extremes, then random ones.
    program_rect(9'd0, 9'd0, 9'd64, 9'd64, 9'd0, 9'd0, 9'd64, 9'd64);
    run_random_phase(80);
    program_rect(9'd255, 9'd255, 9'd511, 9'd511, 9'h100, 9'h100, 9'd511, 9'd511);
    run_random_phase(80);
    program_rect(9'd10, 9'd20, 9'd1, 9'd1, 9'd0, 9'd0, 9'd256, 9'd256);
    run_random_phase(80);
    program_rect(9'd0, 9'd0, 9'd64, 9'd64, 9'h1E0, 9'h1E0, 9'd128, 9'd128);
    run_random_phase(80);
    program_rect(9'd63, 9'd63, 9'd256, 9'd256, 9'h0FF, 9'h0FF, 9'd1, 9'd1);
    run_random_phase(80);
    program_rect(9'd0, 9'd0, 9'd128, 9'd32, 9'd8, 9'h1FC, 9'd40, 9'd100);
    run_random_phase(80);
    for (int p = 0; p < 6; p++) begin
      program_rect(rand_src_origin(), rand_src_origin(), rand_size(), rand_size(),
                   rand_dst_origin(), rand_dst_origin(), rand_size(), rand_size());
      run_random_phase(80);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      report_mismatch("results never returned", '0, 32'(expected_rsp.size()));
    end
    $display("Ran %0d requests under %0d rectangle settings (%0d register writes).",
             accepted_cnt, phase_no + 2, cfg_writes);
    $display("Blits: blended %0d, dest clip %0d, source clip %0d, transparent %0d, %s %0d, %s %0d",
             blit_status_cnt[ST_DONE], blit_status_cnt[ST_DCLIP], blit_status_cnt[ST_SCLIP],
             blit_status_cnt[ST_TRANSP], "empty", blit_status_cnt[ST_EMPTY], "outside",
             blit_status_cnt[ST_OUTSIDE]);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
